// ===== hw/rtl/sbgfd_pkg.sv =====
`default_nettype none
package sbgfd_pkg;

    localparam int MAX_FRAME_BITS = 64;
    localparam int MAX_DIGITS     = 8;

    localparam int HELD_W  = $clog2(MAX_FRAME_BITS + 1);
    localparam int IDX_W   = $clog2(MAX_FRAME_BITS);
    localparam int MAG_W   = 27;
    localparam int VAL_W   = 28;
    localparam int TIME_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CIDX_W  = 3;
    localparam int DCNT_W  = 4;
    localparam int BCD_W   = 4;
    localparam int POS_W   = 8;

    localparam logic [TIME_W-1:0] TIME_SAT  = '1;
    localparam logic [BCD_W-1:0]  BCD_MAX   = 4'd9;
    localparam logic [MAG_W+3:0]  DEC_RADIX = 31'd10;

    typedef enum logic [CIDX_W-1:0] {
        CFG_EXP_BITS  = 3'd0,
        CFG_MSB_FIRST = 3'd1,
        CFG_DATA_START = 3'd2,
        CFG_DIGIT_CNT = 3'd3,
        CFG_SIGN_IDX  = 3'd4,
        CFG_FRAME_TO  = 3'd5,
        CFG_STALE_TO  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        FS_NONE   = 2'd0,
        FS_ACCEPT = 2'd1,
        FS_REJECT = 2'd2
    } t_fstat;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_DIGIT,
        ST_FIN
    } t_state;

    localparam logic REQ_EDGE = 1'b0;

    typedef struct packed {
        logic edge_ld;
        logic tick_ld;
        logic dec_init;
        logic dig_step;
        logic accept;
        logic reject;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic close_req;
        logic pre_fail;
        logic dig_done;
        logic nib_bad;
    } t_sts;

endpackage
`default_nettype wire

// ===== hw/rtl/sbgfd_ctrl.sv =====
`default_nettype none
module sbgfd_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    input  wire logic            i_req_type,
    input  wire logic            i_out_stall,
    input  wire sbgfd_pkg::t_sts i_sts,
    output sbgfd_pkg::t_cmd      o_cmd,
    output logic                 o_in_stall,
    output logic                 o_out_valid
);
    import sbgfd_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_EDGE) begin
                        o_cmd.edge_ld = 1'b1;
                        n_state       = ST_FIN;
                    end else begin
                        o_cmd.tick_ld = 1'b1;
                        n_state       = ST_CLOSE;
                    end
                end
            end
            ST_CLOSE: begin
                if (!i_sts.close_req) begin
                    n_state = ST_FIN;
                end else if (i_sts.pre_fail) begin
                    o_cmd.reject = 1'b1;
                    n_state      = ST_FIN;
                end else begin
                    o_cmd.dec_init = 1'b1;
                    n_state        = ST_DIGIT;
                end
            end
            ST_DIGIT: begin
                if (i_sts.dig_done) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_FIN;
                end else if (i_sts.nib_bad) begin
                    o_cmd.reject = 1'b1;
                    n_state      = ST_FIN;
                end else begin
                    o_cmd.dig_step = 1'b1;
                end
            end
            ST_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_cmd_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(o_cmd)) else $error("more than one datapath command");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_in_stall) else $error("input not held off after accept");
    a_finish_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid) else $error("result lost after finish");
    a_fin_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |-> !o_cmd.finish)
        else $error("waiting result overwritten");

endmodule
`default_nettype wire

// ===== hw/rtl/sbgfd_dp.sv =====
`default_nettype none
module sbgfd_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sbgfd_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire logic [sbgfd_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                                i_data_bit,
    input  wire sbgfd_pkg::t_cmd                     i_cmd,
    output sbgfd_pkg::t_sts                          o_sts,
    output logic                                     o_value_ok,
    output logic signed [sbgfd_pkg::VAL_W-1:0]       o_decoded_value,
    output logic [1:0]                               o_frame_status,
    output logic [sbgfd_pkg::TIME_W-1:0]             o_valid_age_ms
);
    import sbgfd_pkg::*;

    // configuration
    logic [HELD_W-1:0] r_exp_bits;
    logic              r_msb_first;
    logic [IDX_W-1:0]  r_data_start;
    logic [DCNT_W-1:0] r_digit_cnt;
    logic [IDX_W-1:0]  r_sign_idx;
    logic [TIME_W-1:0] r_frame_to;
    logic [TIME_W-1:0] r_stale_to;

    // frame and reading state
    logic [MAX_FRAME_BITS-1:0] r_buf;
    logic [HELD_W-1:0]         r_held;
    logic [TIME_W-1:0]         r_idle;
    logic [TIME_W-1:0]         r_since;
    logic                      r_valid;
    logic [VAL_W-1:0]          r_held_value;
    logic                      r_is_tick;
    t_fstat                    r_fstat;

    // decode walk
    logic [MAG_W-1:0]  r_mag;
    logic [DCNT_W-1:0] r_dig;
    logic [HELD_W-1:0] r_pos;

    logic [MAX_FRAME_BITS-1:0] w_shr;
    logic [HELD_W-1:0]         w_msb_sh;
    logic [BCD_W-1:0]          w_nib;
    logic [MAG_W+3:0]          w_mag_next;
    logic [HELD_W-1:0]         w_sign_pos;
    logic                      w_sign;
    logic [MAG_W-1:0]          w_mag_fin;
    logic [POS_W-1:0]          w_data_end;
    logic                      w_stale;

    // bit at frame position p: arrival order counts back from the newest bit
    assign w_msb_sh = r_held - HELD_W'(BCD_W) - r_pos;
    assign w_shr    = r_msb_first ? (r_buf >> w_msb_sh[IDX_W-1:0])
                                  : (r_buf >> r_pos[IDX_W-1:0]);
    assign w_nib    = r_msb_first ? w_shr[BCD_W-1:0]
                                  : {w_shr[0], w_shr[1], w_shr[2], w_shr[3]};

    assign w_mag_next = {4'd0, r_mag} * DEC_RADIX + {{(MAG_W){1'b0}}, w_nib};

    assign w_sign_pos = r_held - HELD_W'(1) - {1'b0, r_sign_idx};
    assign w_sign     = r_msb_first ? r_buf[w_sign_pos[IDX_W-1:0]] : r_buf[r_sign_idx];
    assign w_mag_fin  = w_sign ? (MAG_W'(0) - r_mag) : r_mag;

    assign w_data_end = {2'd0, r_data_start} + {2'd0, r_digit_cnt, 2'b00};
    assign w_stale    = r_is_tick && (r_since > r_stale_to);

    assign o_sts.close_req = (r_held != '0) && (r_idle >= r_frame_to);
    assign o_sts.pre_fail  = (r_held != r_exp_bits)
                          || (r_digit_cnt > DCNT_W'(MAX_DIGITS))
                          || ({1'b0, r_sign_idx} >= r_held)
                          || (w_data_end > {1'b0, r_held});
    assign o_sts.dig_done  = (r_dig == r_digit_cnt);
    assign o_sts.nib_bad   = (w_nib > BCD_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_bits   <= HELD_W'(52);
            r_msb_first  <= 1'b1;
            r_data_start <= IDX_W'(20);
            r_digit_cnt  <= DCNT_W'(6);
            r_sign_idx   <= IDX_W'(19);
            r_frame_to   <= TIME_W'(20);
            r_stale_to   <= TIME_W'(2000);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_EXP_BITS:   r_exp_bits   <= i_cfg_data[HELD_W-1:0];
                CFG_MSB_FIRST:  r_msb_first  <= i_cfg_data[0];
                CFG_DATA_START: r_data_start <= i_cfg_data[IDX_W-1:0];
                CFG_DIGIT_CNT:  r_digit_cnt  <= i_cfg_data[DCNT_W-1:0];
                CFG_SIGN_IDX:   r_sign_idx   <= i_cfg_data[IDX_W-1:0];
                CFG_FRAME_TO:   r_frame_to   <= i_cfg_data[TIME_W-1:0];
                CFG_STALE_TO:   r_stale_to   <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buf        <= '0;
            r_held       <= '0;
            r_idle       <= '0;
            r_since      <= '0;
            r_valid      <= 1'b0;
            r_held_value <= '0;
            r_is_tick    <= 1'b0;
            r_fstat      <= FS_NONE;
        end else begin
            if (i_cmd.edge_ld) begin
                if (r_held < HELD_W'(MAX_FRAME_BITS)) begin
                    r_buf  <= {r_buf[MAX_FRAME_BITS-2:0], i_data_bit};
                    r_held <= r_held + HELD_W'(1);
                end
                r_idle    <= '0;
                r_is_tick <= 1'b0;
                r_fstat   <= FS_NONE;
            end
            if (i_cmd.tick_ld) begin
                if (r_idle != TIME_SAT)  r_idle  <= r_idle + TIME_W'(1);
                if (r_since != TIME_SAT) r_since <= r_since + TIME_W'(1);
                r_is_tick <= 1'b1;
                r_fstat   <= FS_NONE;
            end
            if (i_cmd.accept) begin
                r_held_value <= {{(VAL_W-MAG_W){w_sign && (r_mag != '0)}}, w_mag_fin};
                r_valid      <= 1'b1;
                r_since      <= '0;
                r_fstat      <= FS_ACCEPT;
                r_buf        <= '0;
                r_held       <= '0;
            end
            if (i_cmd.reject) begin
                r_valid <= 1'b0;
                r_fstat <= FS_REJECT;
                r_buf   <= '0;
                r_held  <= '0;
            end
            if (i_cmd.finish && w_stale) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dec_init) begin
            r_mag <= '0;
            r_dig <= '0;
            r_pos <= {1'b0, r_data_start};
        end else if (i_cmd.dig_step) begin
            r_mag <= w_mag_next[MAG_W-1:0];
            r_dig <= r_dig + DCNT_W'(1);
            r_pos <= r_pos + HELD_W'(BCD_W);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            o_value_ok      <= r_valid && !w_stale;
            o_decoded_value <= r_held_value;
            o_frame_status  <= r_fstat;
            o_valid_age_ms  <= r_since;
        end
    end

    a_held_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= HELD_W'(MAX_FRAME_BITS)) else $error("frame length overflow");
    a_accept_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept |=> (r_valid && (r_since == '0) && (r_held == '0)))
        else $error("accepted frame not recorded");
    a_reject_keeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.reject |=> (!r_valid && $stable(r_held_value)))
        else $error("rejected frame disturbed the reading");

endmodule
`default_nettype wire

// ===== hw/rtl/serial_bcd_gauge_frame_decoder.sv =====
`default_nettype none
// Channel  Direction  Handshake                  Word
// input    in         i_in_valid / o_in_stall    i_req_type, i_data_bit
// output   out        o_out_valid / i_out_stall  o_value_ok, o_decoded_value,
//                                                o_frame_status, o_valid_age_ms
// config   in         i_cfg_we                   i_cfg_index, i_cfg_data
//
// One word at a time. A clock edge word goes straight to the hand-over state.
// A tick goes to the close check, which hands over when it closes no frame or
// an early check rejects the frame, and else starts the one-digit-per-cycle
// decode loop ahead of the hand-over. Reset is synchronous and active low, and
// loads the register defaults. The next word is taken while a result waits
// on a stalled output; a finished result holds until the output is free.
module serial_bcd_gauge_frame_decoder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic [sbgfd_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire logic [sbgfd_pkg::CFG_W-1:0]         i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic                                i_req_type,
    input  wire logic                                i_data_bit,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic                                     o_value_ok,
    output logic signed [sbgfd_pkg::VAL_W-1:0]       o_decoded_value,
    output logic [1:0]                               o_frame_status,
    output logic [sbgfd_pkg::TIME_W-1:0]             o_valid_age_ms
);
    import sbgfd_pkg::*;

    // commands down to the datapath, status back up
    t_cmd w_cmd;
    t_sts w_sts;

    // sequence each word: shift or age, close check, digit walk, hand over
    sbgfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_req_type  (i_req_type),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    // hold the frame, timers, reading and the output register
    sbgfd_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_data_bit      (i_data_bit),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_value_ok      (o_value_ok),
        .o_decoded_value (o_decoded_value),
        .o_frame_status  (o_frame_status),
        .o_valid_age_ms  (o_valid_age_ms)
    );

endmodule
`default_nettype wire
